FILE: rtl/rtd_pkg.sv
package rtd_pkg;

    localparam int DATA_W = 32;
    localparam int SH_W = 6;
    localparam int TABLE_ENTRIES_DEF = 512;
    localparam logic [DATA_W-2:0] RCP_NUMERATOR = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        MODE_UDIV = 2'd0,
        MODE_SDIV = 2'd1,
        MODE_URCP = 2'd2,
        MODE_SRCP = 2'd3
    } mode_t;

    typedef struct packed {
        logic valid;
        logic recip;
        logic neg;
    } ctrl_t;

    // Table entry: (0x7FFFFFFF / idx) * 2, idx 0 gives 0. Long division by
    // shift and subtract; only evaluated on constants at elaboration.
    function automatic logic [DATA_W-1:0] rcp_entry(input int unsigned idx);
        logic [DATA_W-1:0] rem;
        logic [DATA_W-2:0] q;
        logic [DATA_W-1:0] den;
        den = DATA_W'(idx);
        rem = '0;
        q = '0;
        if (idx != 0)
        begin
            for (int k = DATA_W - 2; k >= 0; k--)
            begin
                rem = {rem[DATA_W-2:0], RCP_NUMERATOR[k]};
                if (rem >= den)
                begin
                    rem = rem - den;
                    q[k] = 1'b1;
                end
            end
        end
        return {q, 1'b0};
    endfunction

endpackage

FILE: rtl/rtd_norm.sv
module rtd_norm #(
    parameter int TABLE_ENTRIES = rtd_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req,
    input  logic [1:0]                  mode,
    input  logic [rtd_pkg::DATA_W-1:0]  dividend,
    input  logic [rtd_pkg::DATA_W-1:0]  divisor,
    output rtd_pkg::ctrl_t              ctl_out,
    output logic [rtd_pkg::DATA_W-1:0]  a_out,
    output logic [rtd_pkg::SH_W-1:0]    sh_out,
    output logic [IDX_W-1:0]            idx_out
);

    localparam int DW = rtd_pkg::DATA_W;

    // stage A: operand magnitudes and result sign
    rtd_pkg::ctrl_t    ctl_a_reg, ctl_a_next;
    logic [DW-1:0]     a_a_reg, a_a_next;
    logic [DW-1:0]     b_a_reg, b_a_next;
    // stage B: shift count
    rtd_pkg::ctrl_t    ctl_b_reg;
    logic [DW-1:0]     a_b_reg;
    logic [DW-1:0]     b_b_reg;
    logic [rtd_pkg::SH_W-1:0] sh_b_reg, sh_b_next;
    // stage C: reduced table index
    rtd_pkg::ctrl_t    ctl_c_reg;
    logic [DW-1:0]     a_c_reg;
    logic [rtd_pkg::SH_W-1:0] sh_c_reg;
    logic [IDX_W-1:0]  idx_c_reg, idx_c_next;

    logic neg_a;
    logic neg_b;

    always_comb
    begin
        neg_a = 1'b0;
        neg_b = 1'b0;
        ctl_a_next.valid = req;
        ctl_a_next.recip = 1'b0;
        ctl_a_next.neg = 1'b0;
        case (rtd_pkg::mode_t'(mode))
            rtd_pkg::MODE_UDIV:
            begin
            end
            rtd_pkg::MODE_SDIV:
            begin
                neg_a = dividend[DW-1];
                neg_b = divisor[DW-1];
                ctl_a_next.neg = dividend[DW-1] ^ divisor[DW-1];
            end
            rtd_pkg::MODE_URCP:
            begin
                ctl_a_next.recip = 1'b1;
            end
            rtd_pkg::MODE_SRCP:
            begin
                neg_b = divisor[DW-1];
                ctl_a_next.recip = 1'b1;
                ctl_a_next.neg = divisor[DW-1];
            end
            default:
            begin
            end
        endcase
        a_a_next = neg_a ? (DW'(0) - dividend) : dividend;
        b_a_next = neg_b ? (DW'(0) - divisor) : divisor;
    end

    // Thresholds grow monotonically, so the last one passed gives the count.
    always_comb
    begin
        sh_b_next = '0;
        for (int s = 0; s < DW; s++)
        begin
            if ({{DW{1'b0}}, b_a_reg} >= ((2*DW)'(TABLE_ENTRIES) << s))
            begin
                sh_b_next = rtd_pkg::SH_W'(s + 1);
            end
        end
    end

    assign idx_c_next = IDX_W'(b_b_reg >> sh_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_a_reg <= a_a_next;
        b_a_reg <= b_a_next;
        a_b_reg <= a_a_reg;
        b_b_reg <= b_a_reg;
        sh_b_reg <= sh_b_next;
        a_c_reg <= a_b_reg;
        sh_c_reg <= sh_b_reg;
        idx_c_reg <= idx_c_next;
    end

    assign ctl_out = ctl_c_reg;
    assign a_out = a_c_reg;
    assign sh_out = sh_c_reg;
    assign idx_out = idx_c_reg;

    // shift count is minimal and brings the divisor into table range
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_b_reg.valid |->
            ((DW+1)'(b_b_reg >> sh_b_reg) < (DW+1)'(TABLE_ENTRIES)) &&
            ((sh_b_reg == '0) ||
             ((DW+1)'(b_b_reg >> (sh_b_reg - 1'b1)) >= (DW+1)'(TABLE_ENTRIES))))
    else $error("normalize shift count wrong");

endmodule

FILE: rtl/rtd_rom.sv
module rtd_rom #(
    parameter int TABLE_ENTRIES = rtd_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                        clk,
    input  logic [IDX_W-1:0]            idx,
    output logic [rtd_pkg::DATA_W-1:0]  entry
);

    localparam int DEPTH = 1 << IDX_W;

    logic [rtd_pkg::DATA_W-1:0] rom_w [DEPTH];
    logic [rtd_pkg::DATA_W-1:0] entry_reg;

    // Addresses past the table read 0; the index never reaches them.
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        localparam logic [rtd_pkg::DATA_W-1:0] VAL =
            (g < TABLE_ENTRIES) ? rtd_pkg::rcp_entry(g) : '0;
        assign rom_w[g] = VAL;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= rom_w[idx];
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/rtd_mul.sv
module rtd_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rtd_pkg::ctrl_t              ctl_in,
    input  logic [rtd_pkg::DATA_W-1:0]  a_in,
    input  logic [rtd_pkg::SH_W-1:0]    sh_in,
    input  logic [rtd_pkg::DATA_W-1:0]  entry,
    output logic                        done,
    output logic [rtd_pkg::DATA_W-1:0]  quotient
);

    localparam int DW = rtd_pkg::DATA_W;

    // stage D: aligned with the table read
    rtd_pkg::ctrl_t    ctl_d_reg;
    logic [DW-1:0]     a_d_reg;
    logic [rtd_pkg::SH_W-1:0] sh_d_reg;
    // stage E: scaled reciprocal
    rtd_pkg::ctrl_t    ctl_e_reg;
    logic [DW-1:0]     a_e_reg;
    logic [DW-1:0]     rcp_e_reg, rcp_e_next;
    // stage F: product
    rtd_pkg::ctrl_t    ctl_f_reg;
    logic [DW-1:0]     rcp_f_reg;
    logic [2*DW-1:0]   prod_f_reg, prod_f_next;
    // stage G: output
    logic              done_reg;
    logic [DW-1:0]     quotient_reg, quotient_next;

    logic [DW-1:0]     mag_g;

    assign rcp_e_next = (sh_d_reg >= rtd_pkg::SH_W'(DW)) ? '0 : (entry >> sh_d_reg);
    assign prod_f_next = {{DW{1'b0}}, a_e_reg} * {{DW{1'b0}}, rcp_e_reg};

    always_comb
    begin
        mag_g = ctl_f_reg.recip ? rcp_f_reg : prod_f_reg[2*DW-1:DW];
        quotient_next = ctl_f_reg.neg ? (DW'(0) - mag_g) : mag_g;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_d_reg <= '0;
            ctl_e_reg <= '0;
            ctl_f_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_d_reg <= ctl_in;
            ctl_e_reg <= ctl_d_reg;
            ctl_f_reg <= ctl_e_reg;
            done_reg <= ctl_f_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_d_reg <= a_in;
        sh_d_reg <= sh_in;
        a_e_reg <= a_d_reg;
        rcp_e_reg <= rcp_e_next;
        rcp_f_reg <= rcp_e_reg;
        prod_f_reg <= prod_f_next;
        quotient_reg <= quotient_next;
    end

    assign done = done_reg;
    assign quotient = quotient_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == $past(ctl_f_reg.valid))
    else $error("result strobe out of step with pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_f_reg.valid && rcp_f_reg == '0) |-> (prod_f_reg == '0))
    else $error("product nonzero for zero reciprocal");

    assert property (@(posedge clk) disable iff (!rst_n)
        ctl_e_reg.valid |-> (prod_f_next[2*DW-1:DW] <= a_e_reg))
    else $error("quotient exceeds dividend");

endmodule

FILE: rtl/reciprocal_table_divider_top.sv
// Approximate divider through a reciprocal table. A request is taken on any
// clock edge with start high and busy low; busy is set by reset and is cleared
// by the clock once reset is released, so one request can be issued every
// cycle. Each result appears on quotient with done high for exactly one cycle,
// in request order. The request loads the first of the seven register stages
// on the edge that takes it, and the result is registered in the last one.
// There is no way to hold results off, so the receiver must take every done
// cycle. The seven stages are: operand magnitudes, shift count, index
// reduction, table read, reciprocal scaling, 32x32 multiply, and sign/result
// select. A zero divisor returns 0 in every mode.
module reciprocal_table_divider_top #(
    parameter int TABLE_ENTRIES = rtd_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  mode,
    input  logic [rtd_pkg::DATA_W-1:0]  dividend,
    input  logic [rtd_pkg::DATA_W-1:0]  divisor,
    output logic                        done,
    output logic [rtd_pkg::DATA_W-1:0]  quotient
);

    logic                        busy_reg;
    rtd_pkg::ctrl_t              ctl_c;
    logic [rtd_pkg::DATA_W-1:0]  a_c;
    logic [rtd_pkg::SH_W-1:0]    sh_c;
    logic [IDX_W-1:0]            idx_c;
    logic [rtd_pkg::DATA_W-1:0]  entry_d;

    // hold off requests in reset and until the clock clears this after reset release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;

    rtd_norm #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (start && !busy_reg),
        .mode     (mode),
        .dividend (dividend),
        .divisor  (divisor),
        .ctl_out  (ctl_c),
        .a_out    (a_c),
        .sh_out   (sh_c),
        .idx_out  (idx_c)
    );

    rtd_rom #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_rom (
        .clk   (clk),
        .idx   (idx_c),
        .entry (entry_d)
    );

    rtd_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_c),
        .a_in     (a_c),
        .sh_in    (sh_c),
        .entry    (entry_d),
        .done     (done),
        .quotient (quotient)
    );

endmodule

FILE: bench/reciprocal_table_divider_top_tb.sv
module reciprocal_table_divider_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_W = rtd_pkg::DATA_W;
    localparam int TABLE_SIZE = rtd_pkg::TABLE_ENTRIES_DEF;
    localparam int RANDOM_REQUESTS = 1526;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        rtd_pkg::mode_t     op;
        logic [DATA_W-1:0]  num;
        logic [DATA_W-1:0]  den;
        int unsigned        gap;
    } request_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = rtd_pkg::MODE_UDIV;
    logic [DATA_W-1:0]  dividend = '0;
    logic [DATA_W-1:0]  divisor = '0;
    logic               done;
    logic [DATA_W-1:0]  quotient;

    request_t           pending_requests[$];
    logic [DATA_W-1:0]  expected_quotients[$];
    request_t           next_request;
    logic [DATA_W-1:0]  want;
    int unsigned        hold_off = 0;
    int                 issued = 0;
    int                 checked = 0;
    int                 mismatch_count = 0;
    int                 directed_count = 0;
    int                 mode_hits[4] = '{0, 0, 0, 0};

    reciprocal_table_divider_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .mode     (mode),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (done),
        .quotient (quotient)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Reduce v below the table size, read the entry, scale back by the shift count.
    function automatic logic [DATA_W-1:0] table_reciprocal(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] idx;
        logic [DATA_W-1:0] entry;
        int unsigned shifts;
        idx = v;
        shifts = 0;
        while (idx >= TABLE_SIZE)
        begin
            idx = idx >> 1;
            shifts++;
        end
        entry = (idx == 0) ? '0 :
                ((DATA_W'({1'b0, rtd_pkg::RCP_NUMERATOR}) / idx) << 1);
        return (shifts >= DATA_W) ? '0 : (entry >> shifts);
    endfunction

    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
    endfunction

    function automatic logic [DATA_W-1:0] scaled_product(input logic [DATA_W-1:0] a,
                                                         input logic [DATA_W-1:0] b);
        logic [2*DATA_W-1:0] prod;
        prod = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, table_reciprocal(b)};
        return prod[2*DATA_W-1:DATA_W];
    endfunction

    function automatic logic [DATA_W-1:0] predict_quotient(input rtd_pkg::mode_t op,
                                                           input logic [DATA_W-1:0] a,
                                                           input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        case (op)
            rtd_pkg::MODE_UDIV: r = scaled_product(a, b);
            rtd_pkg::MODE_SDIV:
            begin
                r = scaled_product(magnitude(a), magnitude(b));
                if (a[DATA_W-1] != b[DATA_W-1])
                    r = DATA_W'(0) - r;
            end
            rtd_pkg::MODE_URCP: r = table_reciprocal(b);
            default:
            begin
                r = table_reciprocal(magnitude(b));
                if (b[DATA_W-1])
                    r = DATA_W'(0) - r;
            end
        endcase
        return r;
    endfunction

    task automatic add_request(input rtd_pkg::mode_t op, input logic [DATA_W-1:0] a,
                               input logic [DATA_W-1:0] b, input int unsigned gap);
        request_t r;
        r.op = op;
        r.num = a;
        r.den = b;
        r.gap = gap;
        pending_requests.push_back(r);
    endtask

    function automatic logic [DATA_W-1:0] pick_divisor();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 600);
            1: v = DATA_W'(0) - DATA_W'($urandom_range(1, 600));
            // land on and around each power-of-two boundary of the index reduction
            2: v = (DATA_W'(1) << $urandom_range(0, 31)) + DATA_W'($urandom_range(0, 2)) - 1;
            3: v = DATA_W'($urandom) >> $urandom_range(0, 31);
            4: v = (DATA_W'(TABLE_SIZE - 1) << $urandom_range(0, 23)) | $urandom_range(0, 1);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pick_dividend();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 5000);
            1: v = DATA_W'(0) - DATA_W'($urandom_range(0, 5000));
            2: v = DATA_W'($urandom) >> $urandom_range(0, 31);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Driver: hold a request until taken, then wait its gap before the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            mode <= rtd_pkg::MODE_UDIV;
            dividend <= '0;
            divisor <= '0;
            hold_off <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_quotients.push_back(
                    predict_quotient(rtd_pkg::mode_t'(mode), dividend, divisor));
                issued++;
                mode_hits[mode]++;
            end
            if (!start || !busy)
            begin
                if (hold_off != 0)
                begin
                    start <= 1'b0;
                    hold_off <= hold_off - 1;
                end
                else if (pending_requests.size() != 0)
                begin
                    next_request = pending_requests.pop_front();
                    mode <= next_request.op;
                    dividend <= next_request.num;
                    divisor <= next_request.den;
                    hold_off <= next_request.gap;
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every done cycle must match the oldest outstanding request.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_quotients.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("ERROR: result 0x%08h with no request outstanding", quotient);
                mismatch_count++;
            end
            else
            begin
                want = expected_quotients.pop_front();
                checked++;
                if (quotient !== want)
                begin
                    if (mismatch_count < 10)
                        $display("ERROR: result %0d quotient expected 0x%08h got 0x%08h",
                                 checked, want, quotient);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #1ms;
        $display("ERROR: run timed out");
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        // zero divisor, table edges, most negative value, sign combinations
        add_request(rtd_pkg::MODE_UDIV, 32'd100, 32'd0, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_UDIV, 32'hFFFF_FFFF, 32'd1, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_UDIV, 32'hFFFF_FFFF, 32'd511, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_UDIV, 32'hFFFF_FFFF, 32'd512, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_UDIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_UDIV, 32'd0, 32'd7, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_UDIV, 32'd1000, 32'd3, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, 32'h8000_0000, 32'h8000_0000, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, 32'h8000_0000, 32'd1, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, -32'sd1000, 32'd3, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, 32'd1000, -32'sd3, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, -32'sd1000, -32'sd3, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, 32'd5, 32'd0, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SDIV, 32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_URCP, $urandom, 32'd0, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_URCP, $urandom, 32'd1, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_URCP, $urandom, 32'd511, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_URCP, $urandom, 32'd512, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_URCP, $urandom, 32'hFFFF_FFFF, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SRCP, $urandom, 32'd0, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SRCP, $urandom, 32'h8000_0000, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SRCP, $urandom, 32'hFFFF_FFFF, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SRCP, $urandom, 32'h7FFF_FFFF, $urandom_range(0, 9));
        add_request(rtd_pkg::MODE_SRCP, $urandom, -32'sd512, $urandom_range(0, 9));
        directed_count = pending_requests.size();

        // every fourth block of requests goes back to back
        for (int i = 0; i < RANDOM_REQUESTS; i++)
            add_request(rtd_pkg::mode_t'($urandom_range(0, 3)), pick_dividend(),
                        pick_divisor(), ((i / 150) % 4 == 1) ? 0 : $urandom_range(0, 9));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || start)
            @(posedge clk);
        while (expected_quotients.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d quotients from %0d requests (%0d directed edge cases).",
                 checked, issued, directed_count);
        $display("Requests by mode: udiv %0d, sdiv %0d, urcp %0d, srcp %0d; mismatches %0d.",
                 mode_hits[rtd_pkg::MODE_UDIV], mode_hits[rtd_pkg::MODE_SDIV],
                 mode_hits[rtd_pkg::MODE_URCP], mode_hits[rtd_pkg::MODE_SRCP],
                 mismatch_count);
        if (mismatch_count == 0 && expected_quotients.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: reciprocal_table_divider_top.f
rtl/rtd_pkg.sv
rtl/rtd_norm.sv
rtl/rtd_rom.sv
rtl/rtd_mul.sv
rtl/reciprocal_table_divider_top.sv
bench/reciprocal_table_divider_top_tb.sv
